// ===== src/crc32_byte_stream_macros.svh =====
// Assertion macros shared by the CRC-32 stream block.
`ifndef CRC32_BYTE_STREAM_MACROS_SVH
`define CRC32_BYTE_STREAM_MACROS_SVH

// Same-cycle implication, checked on clk, off while in reset.
`define CRCS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("crcs assertion failed: same-cycle check");

// Next-cycle implication, checked on clk, off while in reset.
`define CRCS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("crcs assertion failed: next-cycle check");

`endif

// ===== src/crcs_pkg.sv =====
// Shared types, constants and the CRC-32 lookup table.
package crcs_pkg;

	localparam logic [31:0] CRC_POLY = 32'hEDB88320;
	localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;

	// Command queue geometry (depth must be a power of two)
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);
	localparam int QCW    = QAW + 1;

	// One classified beat as it travels from front to back
	typedef struct packed {
		logic [7:0] data_byte;
		logic       reload;
		logic       emit;
	} cmd_t;

	// Queue status seen by the front, the back and the checks
	typedef struct packed {
		logic           full;
		logic           empty;
		logic [QCW-1:0] count;
	} fifo_stat_t;

	typedef logic [31:0] crc_tab_t [256];

	// Byte table of the reflected polynomial, built at elaboration
	function automatic crc_tab_t build_crc_tab();
		crc_tab_t tab;
		logic [31:0] c;
		for (int i = 0; i < 256; i++) begin
			c = 32'(i);
			for (int k = 0; k < 8; k++) begin
				if (c[0]) begin
					c = CRC_POLY ^ (c >> 1);
				end else begin
					c = c >> 1;
				end
			end
			tab[i] = c;
		end
		return tab;
	endfunction

	localparam crc_tab_t CRC_TAB = build_crc_tab();

endpackage

// ===== src/crcs_front.sv =====
// Front end: takes input beats and turns them into queue commands.
module crcs_front (
	input  logic                data_valid,
	output logic                data_stall,
	input  logic [7:0]          data_byte,
	input  logic                first_byte,
	input  logic                last_byte,
	input  crcs_pkg::fifo_stat_t stat,
	output logic                push,
	output crcs_pkg::cmd_t      cmd
);

	// Hold off the source only while the queue has no room
	assign data_stall = stat.full;
	assign push       = data_valid && !stat.full;

	// Classify: first flag reloads the register, last flag emits a result
	always_comb begin
		cmd.data_byte = data_byte;
		cmd.reload    = first_byte;
		cmd.emit      = last_byte;
	end

endmodule

// ===== src/crcs_fifo.sv =====
// Short command queue between the front end and the CRC engine.
module crcs_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  crcs_pkg::cmd_t       wr_cmd,
	input  logic                 pop,
	output crcs_pkg::cmd_t       head,
	output crcs_pkg::fifo_stat_t stat
);

	crcs_pkg::cmd_t mem_q [crcs_pkg::QDEPTH];
	logic [crcs_pkg::QAW-1:0] wr_ptr_q;
	logic [crcs_pkg::QAW-1:0] rd_ptr_q;
	logic [crcs_pkg::QCW-1:0] count_q;

	// Storage, no reset needed
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + crcs_pkg::QAW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + crcs_pkg::QAW'(1);
			end
			count_q <= count_q + crcs_pkg::QCW'(push) - crcs_pkg::QCW'(pop);
		end
	end

	assign head       = mem_q[rd_ptr_q];
	assign stat.full  = (count_q == crcs_pkg::QCW'(crcs_pkg::QDEPTH));
	assign stat.empty = (count_q == '0);
	assign stat.count = count_q;

endmodule

// ===== src/crcs_back.sv =====
// Back end: folds queued bytes into the running CRC and holds results.
module crcs_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  crcs_pkg::cmd_t       head,
	input  crcs_pkg::fifo_stat_t stat,
	output logic                 pop,
	output logic                 crc_valid,
	input  logic                 crc_stall,
	output logic [31:0]          crc_value
);

	logic [31:0] crc_q;
	logic [31:0] base;
	logic [31:0] folded;
	logic        out_valid_q;
	logic [31:0] out_crc_q;
	logic        slot_free;

	// Output slot frees up when empty or when its beat is taken now
	assign slot_free = !out_valid_q || !crc_stall;
	assign pop       = !stat.empty && (!head.emit || slot_free);

	// One table lookup and XOR per byte
	assign base   = head.reload ? crcs_pkg::CRC_ONES : crc_q;
	assign folded = crcs_pkg::CRC_TAB[base[7:0] ^ head.data_byte] ^ (base >> 8);

	// Running register; back to all ones after a message ends
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= crcs_pkg::CRC_ONES;
		end else if (pop) begin
			crc_q <= head.emit ? crcs_pkg::CRC_ONES : folded;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && head.emit) begin
			out_valid_q <= 1'b1;
		end else if (!crc_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head.emit) begin
			out_crc_q <= folded ^ crcs_pkg::CRC_ONES;
		end
	end

	assign crc_valid = out_valid_q;
	assign crc_value = out_crc_q;

endmodule

// ===== src/crc32_byte_stream.sv =====
// Top level of the byte-serial CRC-32 engine.
// Computes the reflected CRC-32 (polynomial 0xEDB88320, start all ones, final XOR all ones)
// over messages that arrive one byte per beat. first_byte reloads the register before its
// byte; last_byte ends the message and yields one crc_value beat. The block takes one byte
// every cycle while the queue has room: the byte table lookup and XOR into the running
// register are combinational, and a four-entry command queue plus an output register keep
// input and output apart, so input flows on while a result waits. A result is registered
// after its last byte leaves the queue; the input stalls only once the queue is full.
`include "crc32_byte_stream_macros.svh"

module crc32_byte_stream (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        data_valid,
	output logic        data_stall,
	input  logic [7:0]  data_byte,
	input  logic        first_byte,
	input  logic        last_byte,
	output logic        crc_valid,
	input  logic        crc_stall,
	output logic [31:0] crc_value
);

	crcs_pkg::cmd_t       wr_cmd;
	crcs_pkg::cmd_t       head;
	crcs_pkg::fifo_stat_t stat;
	logic                 push;
	logic                 pop;

	crcs_front u_front (
		.data_valid (data_valid),
		.data_stall (data_stall),
		.data_byte  (data_byte),
		.first_byte (first_byte),
		.last_byte  (last_byte),
		.stat       (stat),
		.push       (push),
		.cmd        (wr_cmd)
	);

	crcs_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_cmd (wr_cmd),
		.pop    (pop),
		.head   (head),
		.stat   (stat)
	);

	crcs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.stat      (stat),
		.pop       (pop),
		.crc_valid (crc_valid),
		.crc_stall (crc_stall),
		.crc_value (crc_value)
	);

	// Checks
	`CRCS_ASSERT_NOW(a_no_overfill, 1'b1, stat.count <= crcs_pkg::QCW'(crcs_pkg::QDEPTH))
	`CRCS_ASSERT_NOW(a_no_empty_pop, stat.empty, !pop)
	`CRCS_ASSERT_NOW(a_no_result_overrun, pop && head.emit, !(crc_valid && crc_stall))
	`CRCS_ASSERT_NEXT(a_emit_shows, pop && head.emit, crc_valid)

endmodule
